// ===== rtl/core/pus_pkg.sv =====
// ----------------------------------------------------------------------------
// pus_pkg
// Shared constants, the quarter-wave sine table and fixed-point helpers for
// the particle update step.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int MAX_PARTICLES    = 8192;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int CNT_W  = $clog2(MAX_PARTICLES);
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SLOT_W = 13;

  localparam logic signed [34:0] ONE_Q16      = 35'sd65536;
  localparam logic [63:0]        HALF_PI_Q61  = 64'h3243F6A8885A308D;
  localparam logic [63:0]        DEPTH_64     = 64'(SINE_TABLE_DEPTH);
  localparam logic [63:0]        HALF_PI_STEP = HALF_PI_Q61 / DEPTH_64;
  localparam logic [63:0]        HALF_PI_REM  = HALF_PI_Q61 % DEPTH_64;

  typedef logic [16:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // (a * b) >> 61 built from 32 bit halves
  function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = {32'd0, a[31:0]};
    bh  = b >> 32;
    bl  = {32'd0, b[31:0]};
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 3) + (mid >> 29);
  endfunction

  // quotient by shift and subtract, for building the sine table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(k * pi / 2 / depth) in Q16.16 by a Taylor series in Q3.61
  function automatic logic [16:0] quarter_sine(input int k);
    logic [63:0] x, x2, term, sum, kk, div;
    logic        done;
    kk   = 64'(k);
    x    = HALF_PI_STEP * kk + udiv64(HALF_PI_REM * kk, DEPTH_64);
    x2   = mul_q61(x, x);
    term = x;
    sum  = x;
    done = 1'b0;
    for (int n = 1; n < 27; n += 2) begin
      if (!done) begin
        div  = 64'((n + 1) * (n + 2));
        term = udiv64(mul_q61(term, x2), div);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if ((n & 3) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return 17'((sum + (64'd1 << 44)) >> 45);
  endfunction

  function automatic sine_tab_t gen_sine_tab();
    sine_tab_t t;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = gen_sine_tab();

  // sine of a 16 bit binary angle, Q16.16
  function automatic logic signed [17:0] trig_q16(input logic [15:0] ang);
    logic [1:0]        quad;
    logic [31:0]       prod;
    logic [IDX_W-1:0]  idx;
    logic signed [17:0] mag;
    quad = ang[15:14];
    prod = 32'(ang[13:0]) * 32'(SINE_TABLE_DEPTH) + 32'd8192;
    idx  = IDX_W'(prod >> 14);
    if (quad[0]) begin
      idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
    end
    mag = $signed({1'b0, SINE_TAB[idx]});
    return quad[1] ? -mag : mag;
  endfunction

  // round(amount * trig / 2^16), ties upward
  function automatic logic signed [33:0] grav_term(input logic signed [31:0] amt,
                                                   input logic signed [17:0] trig);
    logic signed [49:0] p;
    p = {{18{amt[31]}}, amt} * {{32{trig[17]}}, trig};
    p = (p + 50'sd32768) >>> 16;
    return p[33:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/particle_update_step_unit.sv =====
// ----------------------------------------------------------------------------
// particle_update_step_unit
// One frame of Euler integration for one particle per word.
//
// Input channel (in_*): one live particle per word: position, velocity,
// remaining life, gravity amount and direction, and an end-of-list flag.
// Output channel (out_*): one result word per input word, in order: keep
// flag, compacted slot, new position, new velocity, new life, end flag.
// Both channels move a word at an edge where valid is high and stall low.
// The word is held in an input register; the life decrement, table lookup,
// gravity multiply and saturating adds run combinationally; the result
// lands in the output register. Throughput is one word per cycle unless
// the receiver stalls; the multiply-and-add paths to the result register
// sets the clock. While the receiver stalls, the result register holds, one
// further word waits in the input register, and then in_stall rises.
// Reset empties both registers and clears the survivor counter; the counter
// also returns to zero after every word flagged last_of_list.
// ----------------------------------------------------------------------------
module particle_update_step_unit (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_life_left,
  input  logic signed [31:0] in_gravity_amount,
  input  logic        [15:0] in_gravity_angle,
  input  logic               in_last_of_list,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_keep,
  output logic        [12:0] out_slot,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_life,
  output logic               out_end_of_list
);

  // input register
  logic               s1_valid_r;
  logic signed [31:0] s1_pos_x_r, s1_pos_y_r, s1_vel_x_r, s1_vel_y_r;
  logic signed [31:0] s1_life_r, s1_amt_r;
  logic        [15:0] s1_ang_r;
  logic               s1_last_r;

  // result register
  logic               out_valid_r;
  logic               out_keep_r;
  logic        [12:0] out_slot_r;
  logic signed [31:0] out_x_r, out_y_r, out_vx_r, out_vy_r, out_life_r;
  logic               out_last_r;

  logic [pus_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic               adv;
  logic               s1_load;

  logic signed [31:0] life_nxt;
  logic               keep_nxt;
  logic        [12:0] slot_nxt;
  logic signed [31:0] x_nxt, y_nxt, vx_nxt, vy_nxt;
  logic signed [17:0] cos_v, sin_v;
  logic signed [33:0] term_x, term_y;

  assign adv      = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || adv;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_pos_x_r <= in_pos_x;
      s1_pos_y_r <= in_pos_y;
      s1_vel_x_r <= in_vel_x;
      s1_vel_y_r <= in_vel_y;
      s1_life_r  <= in_life_left;
      s1_amt_r   <= in_gravity_amount;
      s1_ang_r   <= in_gravity_angle;
      s1_last_r  <= in_last_of_list;
    end
  end

  always_comb begin
    life_nxt = pus_pkg::sat32({{3{s1_life_r[31]}}, s1_life_r} - pus_pkg::ONE_Q16);
    keep_nxt = (life_nxt > 32'sd0);
    cos_v    = pus_pkg::trig_q16(s1_ang_r + 16'd16384);
    sin_v    = pus_pkg::trig_q16(s1_ang_r);
    term_x   = pus_pkg::grav_term(s1_amt_r, cos_v);
    term_y   = pus_pkg::grav_term(s1_amt_r, sin_v);
    slot_nxt = '0;
    x_nxt    = '0;
    y_nxt    = '0;
    vx_nxt   = '0;
    vy_nxt   = '0;
    if (keep_nxt) begin
      slot_nxt = 13'(cnt_r);
      x_nxt    = s1_pos_x_r + s1_vel_x_r;
      y_nxt    = s1_pos_y_r + s1_vel_y_r;
      vx_nxt   = s1_vel_x_r;
      vy_nxt   = s1_vel_y_r;
      if (s1_amt_r != 32'sd0) begin
        vx_nxt = pus_pkg::sat32({{3{s1_vel_x_r[31]}}, s1_vel_x_r}
                                + {term_x[33], term_x});
        vy_nxt = pus_pkg::sat32({{3{s1_vel_y_r[31]}}, s1_vel_y_r}
                                - {term_y[33], term_y});
      end
    end
  end

  // survivor counter: advance on a kept word, restart after the last word
  always_comb begin
    cnt_nxt = cnt_r;
    if (keep_nxt) begin
      cnt_nxt = (cnt_r == pus_pkg::CNT_W'(pus_pkg::MAX_PARTICLES - 1)) ? '0
                : cnt_r + 1'b1;
    end
    if (s1_last_r) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_keep_r <= keep_nxt;
      out_slot_r <= slot_nxt;
      out_x_r    <= x_nxt;
      out_y_r    <= y_nxt;
      out_vx_r   <= vx_nxt;
      out_vy_r   <= vy_nxt;
      out_life_r <= life_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_keep        = out_keep_r;
  assign out_slot        = out_slot_r;
  assign out_new_x       = out_x_r;
  assign out_new_y       = out_y_r;
  assign out_new_vel_x   = out_vx_r;
  assign out_new_vel_y   = out_vy_r;
  assign out_new_life    = out_life_r;
  assign out_end_of_list = out_last_r;

  // dropped words carry no slot, position or velocity
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_keep_r) |->
      (out_slot_r == '0 && out_x_r == '0 && out_y_r == '0 &&
       out_vx_r == '0 && out_vy_r == '0))
    else $error("dropped word carries nonzero payload");

  // a kept word always has positive life
  a_keep_life: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_keep_r) |-> (out_life_r > 32'sd0))
    else $error("kept word with non-positive life");

  // counter restarts after a word flagged last
  a_cnt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && s1_last_r) |=> (cnt_r == '0))
    else $error("survivor counter not cleared after end of list");

  // counter moves only when a word passes into the result register
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && s1_valid_r) |=> $stable(cnt_r))
    else $error("survivor counter moved without a word");

endmodule

// ===== sim/tb_particle_update_step_unit.sv =====
// ----------------------------------------------------------------------------
// tb_particle_update_step_unit
// Self-checking bench for the particle update step. A queue of particle
// words is streamed in bursts; every accepted word is run through a local
// Q16.16 integrator with its own quarter-wave sine table, and each result
// word is compared field by field with the oldest prediction. The receiver
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_particle_update_step_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] life_left;
    logic signed [31:0] gravity_amount;
    logic        [15:0] gravity_angle;
    logic               last;
    logic               drain_first;
  } particle_t;

  typedef struct {
    logic               keep;
    logic        [12:0] slot;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_life;
    logic               end_of_list;
  } update_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic signed [31:0] in_life_left = '0;
  logic signed [31:0] in_gravity_amount = '0;
  logic        [15:0] in_gravity_angle = '0;
  logic               in_last_of_list = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_keep;
  logic        [12:0] out_slot;
  logic signed [31:0] out_new_x;
  logic signed [31:0] out_new_y;
  logic signed [31:0] out_new_vel_x;
  logic signed [31:0] out_new_vel_y;
  logic signed [31:0] out_new_life;
  logic               out_end_of_list;

  particle_t   particle_q[$];
  update_t     predicted_updates[$];
  particle_t   cur_particle;
  longint      qsine [0:pus_pkg::SINE_TABLE_DEPTH];
  logic [12:0] slot_count = '0;
  int          words_sent = 0;
  int          words_total = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic        offer;
  int          cycle_no = 0;
  int          hold_left = 0;
  int          mode = 0;
  int          mode_left = 0;
  logic        stall_next;

  particle_update_step_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sin(k * pi / 2 / depth) in Q16.16, Taylor series in Q3.61
  function automatic longint quarter_wave(input int k);
    logic [63:0]  x, x2, term, sum, d, kk;
    logic [127:0] wide;
    logic         stop;
    d    = 64'(pus_pkg::SINE_TABLE_DEPTH);
    kk   = 64'(k);
    x    = (pus_pkg::HALF_PI_Q61 / d) * kk + ((pus_pkg::HALF_PI_Q61 % d) * kk) / d;
    wide = {64'd0, x} * {64'd0, x};
    x2   = 64'(wide >> 61);
    term = x;
    sum  = x;
    stop = 1'b0;
    for (int n = 1; n < 27; n += 2) begin
      if (!stop) begin
        wide = {64'd0, term} * {64'd0, x2};
        term = 64'(wide >> 61) / 64'((n + 1) * (n + 2));
        if (term == 64'd0) begin
          stop = 1'b1;
        end else if ((n & 3) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return longint'((sum + (64'd1 << 44)) >> 45);
  endfunction

  function automatic longint table_sine(input logic [15:0] ang);
    int unsigned idx;
    longint      mag;
    idx = (32'(ang[13:0]) * pus_pkg::SINE_TABLE_DEPTH + 8192) >> 14;
    if (ang[14]) begin
      idx = pus_pkg::SINE_TABLE_DEPTH - idx;
    end
    mag = qsine[idx];
    return ang[15] ? -mag : mag;
  endfunction

  // round to Q16.16, ties upward
  function automatic longint scale_gravity(input logic signed [31:0] amt, input longint trig);
    longint prod;
    prod = longint'(amt) * trig;
    return (prod + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic integrate_step(input particle_t p);
    update_t r;
    longint  life_next, vx_next, vy_next;
    r.keep        = 1'b0;
    r.slot        = '0;
    r.new_x       = '0;
    r.new_y       = '0;
    r.new_vel_x   = '0;
    r.new_vel_y   = '0;
    r.end_of_list = p.last;
    life_next     = clamp32(longint'(p.life_left) - 64'sd65536);
    r.new_life    = life_next[31:0];
    if (life_next > 0) begin
      r.keep      = 1'b1;
      r.slot      = slot_count;
      slot_count  = slot_count + 13'd1;
      r.new_x     = p.pos_x + p.vel_x;
      r.new_y     = p.pos_y + p.vel_y;
      r.new_vel_x = p.vel_x;
      r.new_vel_y = p.vel_y;
      if (p.gravity_amount != 0) begin
        vx_next = clamp32(longint'(p.vel_x) + scale_gravity(p.gravity_amount,
                          table_sine(p.gravity_angle + 16'd16384)));
        vy_next = clamp32(longint'(p.vel_y) - scale_gravity(p.gravity_amount,
                          table_sine(p.gravity_angle)));
        r.new_vel_x = vx_next[31:0];
        r.new_vel_y = vy_next[31:0];
      end
    end
    if (p.last) begin
      slot_count = '0;
    end
    predicted_updates.push_back(r);
  endtask

  task automatic add_particle(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] life, input logic [31:0] amt,
                              input logic [15:0] ang, input logic last,
                              input logic drain_first);
    particle_t p;
    p.pos_x          = px;
    p.pos_y          = py;
    p.vel_x          = vx;
    p.vel_y          = vy;
    p.life_left      = life;
    p.gravity_amount = amt;
    p.gravity_angle  = ang;
    p.last           = last;
    p.drain_first    = drain_first;
    particle_q.push_back(p);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h7FFF_FFFF - $urandom_range(0, 262144);
      4: return 32'h8000_0000 + $urandom_range(0, 262144);
      5: return {{12{w[31]}}, w[19:0]};
      default: return w;
    endcase
  endfunction

  function automatic logic [31:0] pick_life();
    case ($urandom_range(0, 9))
      0: return 32'd65536;
      1: return 32'd65537;
      2: return $urandom_range(0, 3 * 65536);
      3: return 32'h8000_0000 + $urandom_range(0, 65536);
      4: return 32'h0 - $urandom_range(0, 65536);
      5: return 32'h7FFF_FFFF - $urandom_range(0, 65536);
      6: return $urandom;
      default: return $urandom_range(65537, 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 4) == 0) begin
      return {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 64)) - 16'd32;
    end
    return 16'($urandom);
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        integrate_step(cur_particle);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (particle_q.size() > 0 &&
                     !(particle_q[0].drain_first && predicted_updates.size() != 0)) begin
          cur_particle      = particle_q.pop_front();
          offer             = 1'b1;
          in_pos_x          <= cur_particle.pos_x;
          in_pos_y          <= cur_particle.pos_y;
          in_vel_x          <= cur_particle.vel_x;
          in_vel_y          <= cur_particle.vel_y;
          in_life_left      <= cur_particle.life_left;
          in_gravity_amount <= cur_particle.gravity_amount;
          in_gravity_angle  <= cur_particle.gravity_angle;
          in_last_of_list   <= cur_particle.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      cycle_no++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (cycle_no == 600) begin
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       stall_next = 1'b0;
        1:       stall_next = ($urandom_range(0, 99) < 30);
        default: stall_next = ($urandom_range(0, 99) < 75);
      endcase
      out_stall <= (hold_left > 0) || stall_next;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_updates.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result word with nothing predicted");
        end
      end else begin
        want = predicted_updates.pop_front();
        check_field("keep", 32'(want.keep), 32'(out_keep));
        check_field("slot", 32'(want.slot), 32'(out_slot));
        check_field("new_x", want.new_x, out_new_x);
        check_field("new_y", want.new_y, out_new_y);
        check_field("new_vel_x", want.new_vel_x, out_new_vel_x);
        check_field("new_vel_y", want.new_vel_y, out_new_vel_y);
        check_field("new_life", want.new_life, out_new_life);
        check_field("end_of_list", 32'(want.end_of_list), 32'(out_end_of_list));
      end
    end
  end

  initial begin
    for (int k = 0; k <= pus_pkg::SINE_TABLE_DEPTH; k++) begin
      qsine[k] = quarter_wave(k);
    end

    // minimal survivor, life exactly spent, zero and negative life, underflow
    add_particle(0, 0, 0, 0, 32'd65537, 0, 16'h0000, 1'b0, 1'b0);
    add_particle(5, 6, 7, 8, 32'd65536, 32'd65536, 16'h1234, 1'b0, 1'b0);
    add_particle(1, 1, 1, 1, 32'd0, 0, 16'h0000, 1'b0, 1'b0);
    add_particle(1, 1, 1, 1, 32'h8000_0000, 0, 16'hFFFF, 1'b0, 1'b0);
    // position wraps both ways
    add_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0,
                 16'h0000, 1'b0, 1'b0);
    add_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0002_0000, 0, 16'h8000, 1'b0, 1'b0);
    // velocity saturation at angles 0x0000, 0x4000 and 0x8000, full-scale pull at 0xC000
    add_particle(0, 0, 32'h7FFF_FFFF, 0, 32'h0010_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0, 1'b0);
    add_particle(0, 0, 32'h8000_0000, 0, 32'h0010_0000, 32'h7FFF_FFFF, 16'h8000, 1'b0, 1'b0);
    add_particle(0, 0, 0, 32'h8000_0000, 32'h0010_0000, 32'h7FFF_FFFF, 16'h4000, 1'b0, 1'b0);
    add_particle(0, 0, 0, 32'h7FFF_FFFF, 32'h0010_0000, 32'h8000_0000, 16'h4000, 1'b0, 1'b0);
    add_particle(3, 4, 5, 6, 32'h0010_0000, 32'h8000_0000, 16'hC000, 1'b0, 1'b0);
    // table rounding and quadrant edges
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'd65536, 16'hFFFF, 1'b0, 1'b0);
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'h0123_4567, 16'd31, 1'b0, 1'b0);
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'h0123_4567, 16'd32, 1'b0, 1'b0);
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'hFEDC_BA98, 16'h3FFF, 1'b0, 1'b0);
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'd1, 16'h2000, 1'b0, 1'b0);
    add_particle(0, 0, 0, 0, 32'h0003_0000, 32'hFFFF_FFFF, 16'h6000, 1'b0, 1'b0);
    // list ends on a dropped word, then on a kept one
    add_particle(9, 9, 9, 9, 32'd100, 0, 16'h0000, 1'b1, 1'b0);
    add_particle(9, 9, 9, 9, 32'h0005_0000, 0, 16'h0000, 1'b0, 1'b0);
    add_particle(9, 9, 9, 9, 32'h0005_0000, 32'd70000, 16'hA5A5, 1'b1, 1'b0);
    add_particle(9, 9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000, 0, 16'h5A5A, 1'b0, 1'b0);

    for (int k = 0; k < 2000; k++) begin
      add_particle(pick_word(), pick_word(), pick_word(), pick_word(), pick_life(),
                   ($urandom_range(0, 4) == 0) ? 32'h0 : pick_word(), pick_angle(),
                   $urandom_range(0, 15) == 0, k == 0 || $urandom_range(0, 499) == 0);
    end
    words_total = particle_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < words_total) @(posedge clk);
    while (predicted_updates.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && predicted_updates.size() == 0) begin
      $display("[particle_update_step_unit] OK");
    end else begin
      $display("[particle_update_step_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[particle_update_step_unit] ERROR");
    $finish;
  end

endmodule
